FILE: hw/rtl/uapq_pkg.sv
// Shared types, constants and codes for the unsorted array priority queue.
`default_nettype none
package uapq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] push_value;
    logic signed [15:0] push_priority;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         entry_count;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] val;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_rd;
    logic shift_wr;
    logic pop_finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_go;
    logic scan_last;
    logic shift_more;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/uapq_dp.sv
// Datapath: entry memory, fill count, scan and shift registers, result register.
`default_nettype none
module uapq_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire uapq_pkg::in_word_t in_data,
  input  wire uapq_pkg::ctl_cmd_t cmd,
  output uapq_pkg::dp_sts_t       sts,
  output uapq_pkg::out_word_t     out_data
);

  uapq_pkg::entry_t mem [uapq_pkg::CAPACITY];
  uapq_pkg::entry_t rdata_r;

  logic [uapq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [uapq_pkg::IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [uapq_pkg::IDX_W-1:0] sh_idx_r, sh_idx_nxt;
  logic [uapq_pkg::IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic signed [15:0]         best_prio_r, best_prio_nxt;
  logic signed [31:0]         best_val_r, best_val_nxt;
  uapq_pkg::out_word_t        out_r, out_nxt;
  logic                       out_load;

  logic                       rd_en, we;
  logic [uapq_pkg::IDX_W-1:0] raddr, waddr;
  uapq_pkg::entry_t           wdata;
  logic                       full, empty, take_best;

  assign full  = (count_r == uapq_pkg::CNT_W'(uapq_pkg::CAPACITY));
  assign empty = (count_r == '0);

  assign sts.pop_go     = (in_data.cmd == uapq_pkg::CMD_POP) && !empty;
  assign sts.scan_last  = (uapq_pkg::CNT_W'(cmp_idx_r) + 1'b1) == count_r;
  assign sts.shift_more = (uapq_pkg::CNT_W'(sh_idx_r) + 1'b1) < count_r;

  // The first entry read always becomes the candidate; later ones replace it
  // only with a strictly larger priority, so the earliest of equals wins.
  assign take_best = (cmp_idx_r == '0) || (rdata_r.prio > best_prio_r);

  always_comb begin
    count_nxt     = count_r;
    cmp_idx_nxt   = cmp_idx_r;
    sh_idx_nxt    = sh_idx_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_val_nxt  = best_val_r;
    out_nxt       = out_r;
    out_load      = 1'b0;
    rd_en         = 1'b0;
    raddr         = '0;
    we            = 1'b0;
    waddr         = count_r[uapq_pkg::IDX_W-1:0];
    wdata.prio    = in_data.push_priority;
    wdata.val     = in_data.push_value;

    if (cmd.load) begin
      out_nxt.popped_value = '0;
      out_nxt.status       = uapq_pkg::ST_OK;
      out_load             = 1'b1;
      unique case (in_data.cmd)
        uapq_pkg::CMD_PUSH: begin
          if (full) begin
            out_nxt.status = uapq_pkg::ST_FULL;
          end else begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        uapq_pkg::CMD_POP: begin
          if (empty) begin
            out_nxt.status = uapq_pkg::ST_EMPTY;
          end else begin
            out_load    = 1'b0;
            rd_en       = 1'b1;
            raddr       = '0;
            cmp_idx_nxt = '0;
          end
        end
        uapq_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
      out_nxt.entry_count = 5'(count_nxt);
    end

    if (cmd.scan) begin
      if (take_best) begin
        best_idx_nxt  = cmp_idx_r;
        best_prio_nxt = rdata_r.prio;
        best_val_nxt  = rdata_r.val;
      end
      if (sts.scan_last) begin
        sh_idx_nxt = best_idx_nxt;
      end else begin
        rd_en       = 1'b1;
        raddr       = cmp_idx_r + 1'b1;
        cmp_idx_nxt = cmp_idx_r + 1'b1;
      end
    end

    if (cmd.shift_rd) begin
      rd_en = 1'b1;
      raddr = sh_idx_r + 1'b1;
    end

    if (cmd.shift_wr) begin
      we         = 1'b1;
      waddr      = sh_idx_r;
      wdata      = rdata_r;
      sh_idx_nxt = sh_idx_r + 1'b1;
    end

    if (cmd.pop_finish) begin
      count_nxt            = count_r - 1'b1;
      out_nxt.popped_value = best_val_r;
      out_nxt.status       = uapq_pkg::ST_OK;
      out_nxt.entry_count  = 5'(count_nxt);
      out_load             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    sh_idx_r    <= sh_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_val_r  <= best_val_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

FILE: hw/rtl/uapq_ctrl.sv
// Controller: sequences scan and shift for a pop and owns the handshakes.
`default_nettype none
module uapq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire uapq_pkg::dp_sts_t sts,
  output uapq_pkg::ctl_cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SHRD = 2'd2;
  localparam logic [1:0] S_SHWR = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // A new word may enter in the cycle its predecessor's result is taken.
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (sts.pop_go) begin
            state_nxt = S_SCAN;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        if (sts.shift_more) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHWR;
        end else begin
          cmd.pop_finish = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/unsorted_array_priority_queue_top.sv
// Top level of the unsorted array priority queue.
// Bounded priority queue of uapq_pkg::CAPACITY entries kept in arrival order in a
// single-port entry memory with registered read. Each word in gives one word out.
// Push, clear, the unused command code and refused commands (push when full, pop
// when empty) have their result registered at acceptance. A pop of a queue holding
// n entries, whose winner sits at index b, first scans all n entries with one
// memory read per entry, then moves the n-1-b entries above the winner down to
// close the gap with one read and one write per entry moved, and then registers its
// result. A new word may be taken in the cycle the previous result is taken.
`default_nettype none
module unsorted_array_priority_queue_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire uapq_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output uapq_pkg::out_word_t     out_data
);

  uapq_pkg::ctl_cmd_t cmd;
  uapq_pkg::dp_sts_t  sts;

  uapq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  uapq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/uapq_checker.sv
// Port-level checker for the priority queue top level and its bind.
`default_nettype none
module uapq_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire uapq_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire uapq_pkg::out_word_t out_data
);

  // An offered command word stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("command word changed while waiting");

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({27'd0, out_data.entry_count} <= uapq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == uapq_pkg::ST_FULL |->
      ({27'd0, out_data.entry_count} == uapq_pkg::CAPACITY)
      && out_data.popped_value == '0)
    else $error("full refusal with wrong count or value");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == uapq_pkg::ST_EMPTY |->
      out_data.entry_count == '0 && out_data.popped_value == '0)
    else $error("empty refusal with wrong count or value");

endmodule

bind unsorted_array_priority_queue_top uapq_checker u_uapq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/tb_unsorted_array_priority_queue_top.sv
// Self-checking testbench for the unsorted array priority queue top level.
`timescale 1ns / 100ps
module tb_unsorted_array_priority_queue_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_WORDS = 900;
  localparam int PHASE_LEN   = 150;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 3 * uapq_pkg::CAPACITY + 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  uapq_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  uapq_pkg::out_word_t out_data;

  unsorted_array_priority_queue_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the queue contents, kept in arrival order.
  logic signed [31:0] shadow_val [uapq_pkg::CAPACITY];
  logic signed [15:0] shadow_pri [uapq_pkg::CAPACITY];
  int                 shadow_cnt = 0;

  uapq_pkg::in_word_t  pending_cmds [$];
  uapq_pkg::out_word_t due_results [$];

  int words_in = 0;
  int words_out = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;
  int n_push_ok = 0, n_push_full = 0, n_pop_ok = 0, n_pop_empty = 0;
  int n_clear = 0, n_unused = 0;

  // Idle pattern rotates every PHASE_LEN words: none, sender, receiver, both.
  int unsigned idle_phase;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  assign idle_phase     = (words_in / PHASE_LEN) % 4;
  assign send_gap_pct   = (idle_phase == 1) ? 71 : (idle_phase == 3) ? 23 : 0;
  assign recv_stall_pct = (idle_phase == 2) ? 71 : (idle_phase == 3) ? 23 : 0;

  // Applies one command to the shadow queue and returns the word it must produce.
  function automatic uapq_pkg::out_word_t apply_cmd(input uapq_pkg::in_word_t w);
    uapq_pkg::out_word_t r;
    int                  best;
    r = '0;
    r.status = uapq_pkg::ST_OK;
    case (w.cmd)
      uapq_pkg::CMD_PUSH: begin
        if (shadow_cnt >= uapq_pkg::CAPACITY) begin
          r.status = uapq_pkg::ST_FULL;
          n_push_full++;
        end else begin
          shadow_val[shadow_cnt] = w.push_value;
          shadow_pri[shadow_cnt] = w.push_priority;
          shadow_cnt++;
          n_push_ok++;
        end
      end
      uapq_pkg::CMD_POP: begin
        if (shadow_cnt == 0) begin
          r.status = uapq_pkg::ST_EMPTY;
          n_pop_empty++;
        end else begin
          // Strictly greater keeps the earliest entry among equal priorities.
          best = 0;
          for (int i = 1; i < shadow_cnt; i++) begin
            if (shadow_pri[i] > shadow_pri[best]) best = i;
          end
          r.popped_value = shadow_val[best];
          for (int i = best; i + 1 < shadow_cnt; i++) begin
            shadow_val[i] = shadow_val[i + 1];
            shadow_pri[i] = shadow_pri[i + 1];
          end
          shadow_cnt--;
          n_pop_ok++;
        end
      end
      uapq_pkg::CMD_CLEAR: begin
        shadow_cnt = 0;
        n_clear++;
      end
      default: begin
        n_unused++;
      end
    endcase
    r.entry_count = shadow_cnt[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Driver: presents pending words and feeds each accepted one to the shadow queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_cmds.delete(0);
        due_results.push_back(apply_cmd(in_data));
        words_in++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_cmds[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result word against the oldest one due.
  always @(posedge clk) begin : monitor
    uapq_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing due", words_out));
        end else begin
          want = due_results.pop_front();
          if (out_data.popped_value !== want.popped_value)
            report_mismatch($sformatf("word %0d popped_value got %0d want %0d", words_out,
                                      out_data.popped_value, want.popped_value));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("word %0d status got %0d want %0d", words_out,
                                      out_data.status, want.status));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("word %0d entry_count got %0d want %0d", words_out,
                                      out_data.entry_count, want.entry_count));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Count of entries the queue will hold, tracked while the stimulus is built.
  int gen_cnt = 0;
  int gen_words = 0;

  task automatic queue_cmd(input logic [1:0] c, input logic signed [31:0] v,
                           input logic signed [15:0] p);
    uapq_pkg::in_word_t w;
    w.cmd           = c;
    w.push_value    = v;
    w.push_priority = p;
    pending_cmds.push_back(w);
    if (c != CMD_UNUSED) gen_words++;
    case (c)
      uapq_pkg::CMD_PUSH:  if (gen_cnt < uapq_pkg::CAPACITY) gen_cnt++;
      uapq_pkg::CMD_POP:   if (gen_cnt > 0) gen_cnt--;
      uapq_pkg::CMD_CLEAR: gen_cnt = 0;
      default:             ;
    endcase
  endtask

  // Narrow ranges and the two field extremes give many equal priorities; mode 1 spreads across the field.
  function automatic logic signed [15:0] pick_prio(input int mode);
    logic signed [15:0] p;
    case (mode)
      0:       p = 16'($urandom_range(4)) - 16'sd2;
      1:       p = 16'($urandom);
      2:       p = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: p = 16'($urandom_range(7)) + 16'sh7ff8;
    endcase
    return p;
  endfunction

  initial begin
    int kind;
    int mode;
    int k;

    // Directed part: field extremes, equal priorities, refusals, clear and code 3.
    queue_cmd(uapq_pkg::CMD_PUSH, 32'sh7fffffff, 16'sh7fff);
    queue_cmd(uapq_pkg::CMD_PUSH, 32'sh80000000, 16'sh8000);
    queue_cmd(uapq_pkg::CMD_PUSH, -32'sd1, 16'sd0);
    queue_cmd(uapq_pkg::CMD_PUSH, 32'sd5, 16'sd0);
    queue_cmd(uapq_pkg::CMD_PUSH, 32'sd0, -16'sd1);
    queue_cmd(uapq_pkg::CMD_POP, 32'sh7fffffff, 16'sh7fff);
    queue_cmd(uapq_pkg::CMD_POP, 32'sh80000000, 16'sh8000);
    queue_cmd(uapq_pkg::CMD_POP, 32'($urandom), 16'($urandom));
    while (gen_cnt < uapq_pkg::CAPACITY)
      queue_cmd(uapq_pkg::CMD_PUSH, 32'($urandom), 16'($urandom));
    queue_cmd(uapq_pkg::CMD_PUSH, 32'($urandom), 16'($urandom));
    queue_cmd(CMD_UNUSED, 32'($urandom), 16'($urandom));
    queue_cmd(uapq_pkg::CMD_CLEAR, 32'($urandom), 16'($urandom));
    queue_cmd(uapq_pkg::CMD_POP, 32'($urandom), 16'($urandom));

    // Random part: mostly push runs followed by pop runs, plus noise.
    while (gen_words < TOTAL_WORDS) begin
      kind = $urandom_range(99);
      mode = $urandom_range(3);
      if (kind < 40) begin
        if (gen_cnt < uapq_pkg::CAPACITY) begin
          k = $urandom_range(1, uapq_pkg::CAPACITY - gen_cnt);
          repeat (k) queue_cmd(uapq_pkg::CMD_PUSH, 32'($urandom), pick_prio(mode));
        end
        k = $urandom_range(1, gen_cnt);
        repeat (k) queue_cmd(uapq_pkg::CMD_POP, 32'($urandom), 16'($urandom));
      end else if (kind < 60) begin
        while (gen_cnt < uapq_pkg::CAPACITY)
          queue_cmd(uapq_pkg::CMD_PUSH, 32'($urandom), pick_prio(mode));
        repeat ($urandom_range(1, 2))
          queue_cmd(uapq_pkg::CMD_PUSH, 32'($urandom), pick_prio(mode));
        if ($urandom_range(3) == 0) begin
          queue_cmd(uapq_pkg::CMD_CLEAR, 32'($urandom), 16'($urandom));
        end else begin
          while (gen_cnt > 0) queue_cmd(uapq_pkg::CMD_POP, 32'($urandom), 16'($urandom));
        end
        queue_cmd(uapq_pkg::CMD_POP, 32'($urandom), 16'($urandom));
      end else if (kind < 85) begin
        repeat (8) begin
          if ($urandom_range(1) && gen_cnt < uapq_pkg::CAPACITY)
            queue_cmd(uapq_pkg::CMD_PUSH, 32'($urandom), pick_prio(mode));
          else
            queue_cmd(uapq_pkg::CMD_POP, 32'($urandom), 16'($urandom));
        end
      end else begin
        repeat (6) queue_cmd(2'($urandom_range(3)), 32'($urandom), pick_prio(mode));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() > 0 || due_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", due_results.size()));

    $display("covered %0d words in, %0d out: %0d pushes, %0d refused full, %0d pops,",
             words_in, words_out, n_push_ok, n_push_full, n_pop_ok);
    $display("  %0d refused empty, %0d clears, %0d unused codes; %0d mismatches",
             n_pop_empty, n_clear, n_unused, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
